@@ rtl/iowm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the I2C display write master: phase codes, register indexes,
// register reset values and the result record. No dependencies.
package iowm_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 10;
  localparam int unsigned PollWidth     = 10;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DEVICE_ADDRESS  = 2'd0,
    CFG_COMMAND_CONTROL = 2'd1,
    CFG_DATA_CONTROL    = 2'd2,
    CFG_ACK_POLL_LIMIT  = 2'd3
  } cfg_index_t;

  localparam logic [7:0]           DeviceAddressReset  = 8'h78;
  localparam logic [7:0]           CommandControlReset = 8'h00;
  localparam logic [7:0]           DataControlReset    = 8'h40;
  localparam logic [PollWidth-1:0] AckPollLimitReset   = 10'd250;
  localparam logic [1:0]           NackMax             = 2'd3;

  // Phase says what the next tick does.
  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_ST2    = 10'b00_0000_0010,
    PH_ST3    = 10'b00_0000_0100,
    PH_BITLO  = 10'b00_0000_1000,
    PH_BITHI  = 10'b00_0001_0000,
    PH_ACKREL = 10'b00_0010_0000,
    PH_POLL   = 10'b00_0100_0000,
    PH_NEXT   = 10'b00_1000_0000,
    PH_NSTOP2 = 10'b01_0000_0000,
    PH_FSTOP2 = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_on;
    logic       busy_res;
    logic       done_res;
    logic [1:0] missed_acks;
  } result_t;

endpackage

@@ rtl/iowm_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for tick/request items and line-level results.
// Depends on nothing.
interface iowm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       is_data;
  logic [7:0] payload;
  logic       sda_sense;

  modport source (output valid, op, is_data, payload, sda_sense, input ready);
  modport sink   (input valid, op, is_data, payload, sda_sense, output ready);
endinterface

interface iowm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive_on;
  logic       busy_res;
  logic       done_res;
  logic [1:0] missed_acks;

  modport source (output valid, scl_level, sda_level, sda_drive_on, busy_res,
                  done_res, missed_acks, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive_on, busy_res,
                  done_res, missed_acks, output ready);
endinterface

@@ rtl/iowm_seq.sv @@
`timescale 1ns / 1ps
// Line-level write sequencer: configuration registers, sequence state and
// the per-item next-state logic. Depends on iowm_pkg.
module iowm_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [iowm_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [iowm_pkg::CfgDataWidth-1:0]     cfg_data,
  input  logic                                  step,
  input  logic                                  op,
  input  logic                                  is_data,
  input  logic [7:0]                            payload,
  input  logic                                  sda_sense,
  output iowm_pkg::result_t                     result
);

  logic [7:0]                     device_address;
  logic [7:0]                     command_control;
  logic [7:0]                     data_control;
  logic [iowm_pkg::PollWidth-1:0] ack_poll_limit;

  iowm_pkg::phase_t               phase, phase_next;
  logic [2:0]                     bit_index, bit_index_next;
  logic [1:0]                     byte_index, byte_index_next;
  logic [7:0]                     shift_byte, shift_byte_next;
  logic [iowm_pkg::PollWidth-1:0] poll_count, poll_count_next;
  logic [1:0]                     nack_total, nack_total_next;
  logic [7:0]                     payload_hold, payload_hold_next;
  logic                           kind_hold, kind_hold_next;
  logic                           scl, scl_next;
  logic                           sda, sda_next;
  logic                           drive, drive_next;
  logic                           done;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= iowm_pkg::DeviceAddressReset;
      command_control <= iowm_pkg::CommandControlReset;
      data_control    <= iowm_pkg::DataControlReset;
      ack_poll_limit  <= iowm_pkg::AckPollLimitReset;
    end else if (cfg_we) begin
      unique case (iowm_pkg::cfg_index_t'(cfg_index))
        iowm_pkg::CFG_DEVICE_ADDRESS:  device_address  <= cfg_data[7:0];
        iowm_pkg::CFG_COMMAND_CONTROL: command_control <= cfg_data[7:0];
        iowm_pkg::CFG_DATA_CONTROL:    data_control    <= cfg_data[7:0];
        iowm_pkg::CFG_ACK_POLL_LIMIT:  ack_poll_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    shift_byte_next   = shift_byte;
    poll_count_next   = poll_count;
    nack_total_next   = nack_total;
    payload_hold_next = payload_hold;
    kind_hold_next    = kind_hold;
    scl_next          = scl;
    sda_next          = sda;
    drive_next        = drive;
    done              = 1'b0;
    if (op) begin
      // Requests while busy are dropped without effect.
      if (phase == iowm_pkg::PH_IDLE) begin
        payload_hold_next = payload;
        kind_hold_next    = is_data;
        nack_total_next   = 2'd0;
        byte_index_next   = 2'd0;
        bit_index_next    = 3'd0;
        poll_count_next   = '0;
        shift_byte_next   = device_address;
        scl_next          = 1'b1;
        sda_next          = 1'b1;
        drive_next        = 1'b1;
        phase_next        = iowm_pkg::PH_ST2;
      end
    end else begin
      unique case (phase)
        iowm_pkg::PH_IDLE: ;
        iowm_pkg::PH_ST2: begin
          sda_next   = 1'b0;
          scl_next   = 1'b1;
          drive_next = 1'b1;
          phase_next = iowm_pkg::PH_ST3;
        end
        iowm_pkg::PH_ST3: begin
          scl_next   = 1'b0;
          sda_next   = 1'b0;
          drive_next = 1'b1;
          phase_next = iowm_pkg::PH_BITLO;
        end
        iowm_pkg::PH_BITLO: begin
          scl_next   = 1'b0;
          drive_next = 1'b1;
          phase_next = iowm_pkg::PH_BITHI;
        end
        iowm_pkg::PH_BITHI: begin
          scl_next        = 1'b1;
          sda_next        = shift_byte[7];
          drive_next      = 1'b1;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_index + 3'd1;
          phase_next      = (bit_index == 3'd7) ? iowm_pkg::PH_ACKREL
                                                : iowm_pkg::PH_BITLO;
        end
        iowm_pkg::PH_ACKREL: begin
          scl_next        = 1'b1;
          drive_next      = 1'b0;
          poll_count_next = '0;
          phase_next      = iowm_pkg::PH_POLL;
        end
        iowm_pkg::PH_POLL: begin
          if (!sda_sense) begin
            scl_next   = 1'b0;
            drive_next = 1'b0;
            phase_next = iowm_pkg::PH_NEXT;
          end else if (poll_count >= ack_poll_limit) begin
            if (nack_total != iowm_pkg::NackMax) begin
              nack_total_next = nack_total + 2'd1;
            end
            scl_next   = 1'b1;
            sda_next   = 1'b0;
            drive_next = 1'b1;
            phase_next = iowm_pkg::PH_NSTOP2;
          end else begin
            poll_count_next = poll_count + 1'b1;
          end
        end
        iowm_pkg::PH_NSTOP2: begin
          scl_next   = 1'b1;
          sda_next   = 1'b1;
          drive_next = 1'b1;
          phase_next = iowm_pkg::PH_NEXT;
        end
        iowm_pkg::PH_NEXT: begin
          byte_index_next = byte_index + 2'd1;
          if (byte_index == 2'd0 || byte_index == 2'd1) begin
            shift_byte_next = (byte_index == 2'd0)
                              ? (kind_hold ? data_control : command_control)
                              : payload_hold;
            bit_index_next  = 3'd0;
            scl_next        = 1'b0;
            drive_next      = 1'b1;
            phase_next      = iowm_pkg::PH_BITHI;
          end else begin
            scl_next   = 1'b1;
            sda_next   = 1'b0;
            drive_next = 1'b1;
            phase_next = iowm_pkg::PH_FSTOP2;
          end
        end
        iowm_pkg::PH_FSTOP2: begin
          scl_next   = 1'b1;
          sda_next   = 1'b1;
          drive_next = 1'b1;
          done       = 1'b1;
          phase_next = iowm_pkg::PH_IDLE;
        end
        default: phase_next = iowm_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= iowm_pkg::PH_IDLE;
      bit_index  <= 3'd0;
      byte_index <= 2'd0;
      poll_count <= '0;
      nack_total <= 2'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      drive      <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      byte_index <= byte_index_next;
      poll_count <= poll_count_next;
      nack_total <= nack_total_next;
      scl        <= scl_next;
      sda        <= sda_next;
      drive      <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_byte   <= shift_byte_next;
      payload_hold <= payload_hold_next;
      kind_hold    <= kind_hold_next;
    end
  end

  always_comb begin
    result.scl_level    = scl_next;
    result.sda_level    = sda_next;
    result.sda_drive_on = drive_next;
    result.busy_res     = (phase_next != iowm_pkg::PH_IDLE);
    result.done_res     = done;
    result.missed_acks  = nack_total_next;
  end

endmodule

@@ rtl/iowm_skid.sv @@
`timescale 1ns / 1ps
// Two-entry output buffer for result records: a main register and a skid
// register, so input is taken while one result waits. Depends on iowm_pkg.
module iowm_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  iowm_pkg::result_t push_data,
  output logic              space,
  output logic              main_valid,
  output iowm_pkg::result_t main_data,
  input  logic              pop_ready
);

  logic              side_valid;
  iowm_pkg::result_t side_data;
  logic              pop;

  assign space = !side_valid;
  assign pop   = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      side_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (side_valid) begin
          main_data  <= side_data;
          side_valid <= 1'b0;
        end else if (push) begin
          main_data <= push_data;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        if (main_valid) begin
          side_data  <= push_data;
          side_valid <= 1'b1;
        end else begin
          main_data  <= push_data;
          main_valid <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/i2c_oled_write_master.sv @@
`timescale 1ns / 1ps
// Top level of the I2C display write master: sequencer plus output buffer.
// Depends on iowm_pkg, iowm_if, iowm_seq and iowm_skid.
//
// Usage:
//   in_ch carries one item per transfer: a tick (op = 0), which is one
//   half-bit slot or one acknowledge poll using sda_sense, or a write request
//   (op = 1) with is_data and payload. Every item yields exactly one result
//   on out_ch: the SCL/SDA levels and SDA drive after that item, busy, a
//   one-item done pulse at the end of the final stop, and missed acks.
//   Each result is registered in the output buffer when its input transfers.
//   Throughput: one item per clock while the buffer has room; the state update
//   is a single pass of next-state logic between the sequence registers.
//   A stalled receiver is absorbed by a two-entry output buffer: input is
//   still taken while one result waits, and ready drops only when both
//   entries are full, resuming the cycle after the receiver takes one.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//   write only while idle. Index 0 device address, 1 command control byte,
//   2 data control byte, 3 acknowledge poll limit.
//   Reset (rst, synchronous): registers to their defaults, sequencer idle
//   with SCL high, SDA high and driven, nack count zero, buffer empty.
module i2c_oled_write_master_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [iowm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [iowm_pkg::CfgDataWidth-1:0]  cfg_data,
  iowm_in_if.sink                            in_ch,
  iowm_out_if.source                         out_ch
);

  logic              step;
  logic              space;
  iowm_pkg::result_t seq_result;
  iowm_pkg::result_t out_result;

  // Take an item whenever the buffer has room.
  assign in_ch.ready = space;
  assign step        = in_ch.valid && space;

  iowm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .op        (in_ch.op),
    .is_data   (in_ch.is_data),
    .payload   (in_ch.payload),
    .sda_sense (in_ch.sda_sense),
    .result    (seq_result)
  );

  iowm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (seq_result),
    .space      (space),
    .main_valid (out_ch.valid),
    .main_data  (out_result),
    .pop_ready  (out_ch.ready)
  );

  assign out_ch.scl_level    = out_result.scl_level;
  assign out_ch.sda_level    = out_result.sda_level;
  assign out_ch.sda_drive_on = out_result.sda_drive_on;
  assign out_ch.busy_res     = out_result.busy_res;
  assign out_ch.done_res     = out_result.done_res;
  assign out_ch.missed_acks  = out_result.missed_acks;

  // Done closes the write, so the sequencer is idle on that result.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done result still reports busy");

  // SDA is only released inside an acknowledge wait of a running write.
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.sda_drive_on |-> out_ch.busy_res)
    else $error("SDA released while idle");

  // Input stalls only when the buffer holds a waiting result.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output");

  // A done pulse comes with SCL and SDA both high and driven.
  a_done_lines: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |->
      out_ch.scl_level && out_ch.sda_level && out_ch.sda_drive_on)
    else $error("done without stop line levels");

endmodule

@@ tb/i2c_oled_write_master_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for i2c_oled_write_master_core: drives tick/request items,
// predicts every line-level result in step with the sequencer, checks each one.
// Depends on iowm_pkg, iowm_if and the core RTL.
module i2c_oled_write_master_core_tb;

  // Item opcodes and request kinds.
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_REQUEST   = 1'b1;
  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_DATA    = 1'b1;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned ITEMS_PER_MIX  = 200;

  typedef struct packed {
    logic       op;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_sense;
  } line_item_t;

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [iowm_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [iowm_pkg::CfgDataWidth-1:0]  cfg_data;

  iowm_in_if  item_ch ();
  iowm_out_if line_ch ();

  i2c_oled_write_master_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (item_ch),
    .out_ch    (line_ch)
  );

  // 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Register copies as the sequencer should see them.
  logic [7:0]                     addr_reg;
  logic [7:0]                     cmd_ctrl_reg;
  logic [7:0]                     data_ctrl_reg;
  logic [iowm_pkg::PollWidth-1:0] poll_limit_reg;

  // Sequencer state tracked by the predictor.
  iowm_pkg::phase_t               seq_phase;
  logic [2:0]                     bit_cnt;
  logic [1:0]                     byte_cnt;
  logic [7:0]                     shift_q;
  logic [iowm_pkg::PollWidth-1:0] polls;
  logic [1:0]                     nacks;
  logic [7:0]                     held_payload;
  logic                           held_kind;
  logic                           scl_q;
  logic                           sda_q;
  logic                           drv_q;

  iowm_pkg::result_t line_expect_q[$];
  int unsigned       error_count;
  int unsigned       quiet_cycles;
  int unsigned       counted_items;
  int                send_idle_pct;
  int                recv_stall_pct;

  task automatic report_mismatch(input string what, input int unsigned expv,
                                 input int unsigned gotv);
    $display("%0t ns: %s expected %0d got %0d", $time, what, expv, gotv);
    error_count++;
  endtask

  task automatic reset_model();
    addr_reg       = iowm_pkg::DeviceAddressReset;
    cmd_ctrl_reg   = iowm_pkg::CommandControlReset;
    data_ctrl_reg  = iowm_pkg::DataControlReset;
    poll_limit_reg = iowm_pkg::AckPollLimitReset;
    seq_phase      = iowm_pkg::PH_IDLE;
    bit_cnt        = '0;
    byte_cnt       = '0;
    shift_q        = '0;
    polls          = '0;
    nacks          = '0;
    held_payload   = '0;
    held_kind      = 1'b0;
    scl_q          = 1'b1;
    sda_q          = 1'b1;
    drv_q          = 1'b1;
  endtask

  // Advance the tracked sequencer by one item and return the line levels after it.
  function automatic iowm_pkg::result_t step_sequencer(input line_item_t it);
    iowm_pkg::result_t r;
    logic              done;
    done = 1'b0;
    if (it.op == OP_REQUEST) begin
      // A request while busy leaves everything as it was.
      if (seq_phase == iowm_pkg::PH_IDLE) begin
        held_payload = it.payload;
        held_kind    = it.is_data;
        nacks        = '0;
        byte_cnt     = '0;
        bit_cnt      = '0;
        polls        = '0;
        shift_q      = addr_reg;
        {scl_q, sda_q, drv_q} = 3'b111;
        seq_phase    = iowm_pkg::PH_ST2;
      end
    end else begin
      case (seq_phase)
        iowm_pkg::PH_ST2: begin
          {scl_q, sda_q, drv_q} = 3'b101;
          seq_phase = iowm_pkg::PH_ST3;
        end
        iowm_pkg::PH_ST3: begin
          {scl_q, sda_q, drv_q} = 3'b001;
          seq_phase = iowm_pkg::PH_BITLO;
        end
        iowm_pkg::PH_BITLO: begin
          scl_q     = 1'b0;
          drv_q     = 1'b1;
          seq_phase = iowm_pkg::PH_BITHI;
        end
        iowm_pkg::PH_BITHI: begin
          {scl_q, sda_q, drv_q} = {1'b1, shift_q[7], 1'b1};
          shift_q   = {shift_q[6:0], 1'b0};
          bit_cnt   = bit_cnt + 3'd1;
          seq_phase = (bit_cnt == 3'd0) ? iowm_pkg::PH_ACKREL : iowm_pkg::PH_BITLO;
        end
        iowm_pkg::PH_ACKREL: begin
          scl_q     = 1'b1;
          drv_q     = 1'b0;
          polls     = '0;
          seq_phase = iowm_pkg::PH_POLL;
        end
        iowm_pkg::PH_POLL: begin
          if (!it.sda_sense) begin
            scl_q     = 1'b0;
            drv_q     = 1'b0;
            seq_phase = iowm_pkg::PH_NEXT;
          end else if (polls >= poll_limit_reg) begin
            // Missed acknowledge: count it and send a stop.
            if (nacks != iowm_pkg::NackMax) nacks = nacks + 2'd1;
            {scl_q, sda_q, drv_q} = 3'b101;
            seq_phase = iowm_pkg::PH_NSTOP2;
          end else begin
            polls = polls + 1'b1;
          end
        end
        iowm_pkg::PH_NSTOP2: begin
          {scl_q, sda_q, drv_q} = 3'b111;
          seq_phase = iowm_pkg::PH_NEXT;
        end
        iowm_pkg::PH_NEXT: begin
          byte_cnt = byte_cnt + 2'd1;
          if (byte_cnt == 2'd1 || byte_cnt == 2'd2) begin
            if (byte_cnt == 2'd1) shift_q = held_kind ? data_ctrl_reg : cmd_ctrl_reg;
            else shift_q = held_payload;
            bit_cnt   = '0;
            scl_q     = 1'b0;
            drv_q     = 1'b1;
            seq_phase = iowm_pkg::PH_BITHI;
          end else begin
            {scl_q, sda_q, drv_q} = 3'b101;
            seq_phase = iowm_pkg::PH_FSTOP2;
          end
        end
        iowm_pkg::PH_FSTOP2: begin
          {scl_q, sda_q, drv_q} = 3'b111;
          done      = 1'b1;
          seq_phase = iowm_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.sda_drive_on = drv_q;
    r.busy_res     = (seq_phase != iowm_pkg::PH_IDLE);
    r.done_res     = done;
    r.missed_acks  = nacks;
    return r;
  endfunction

  // Send one item: optional sender gap, hold valid until ready, predict on transfer.
  // Called and returning at a falling edge.
  task automatic send_item(input line_item_t it);
    logic ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid     = 1'b1;
    item_ch.op        = it.op;
    item_ch.is_data   = it.is_data;
    item_ch.payload   = it.payload;
    item_ch.sda_sense = it.sda_sense;
    do @(posedge clk); while (!item_ch.ready);
    ignored = (it.op == OP_REQUEST) ? (seq_phase != iowm_pkg::PH_IDLE)
                                    : (seq_phase == iowm_pkg::PH_IDLE);
    if (!ignored) counted_items++;
    line_expect_q.push_back(step_sequencer(it));
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  task automatic send_tick(input logic sense);
    send_item('{OP_TICK, 1'($urandom_range(1)), 8'($urandom), sense});
  endtask

  // Hold until every expected result has been taken.
  task automatic wait_results_drained();
    while (line_expect_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write one register with the sequencer idle and nothing in flight.
  task automatic write_reg(input iowm_pkg::cfg_index_t idx,
                           input logic [iowm_pkg::CfgDataWidth-1:0] val);
    wait_results_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_data  = iowm_pkg::CfgDataWidth'($urandom);
    case (idx)
      iowm_pkg::CFG_DEVICE_ADDRESS:  addr_reg       = val[7:0];
      iowm_pkg::CFG_COMMAND_CONTROL: cmd_ctrl_reg   = val[7:0];
      iowm_pkg::CFG_DATA_CONTROL:    data_ctrl_reg  = val[7:0];
      iowm_pkg::CFG_ACK_POLL_LIMIT:  poll_limit_reg = val[iowm_pkg::PollWidth-1:0];
      default: ;
    endcase
  endtask

  // One complete write: request, then ticks until the final stop.
  // high_pct sets how often a poll sees SDA high; busy_pct mixes in requests
  // that arrive while busy and must be ignored.
  task automatic run_write(input logic kind, input logic [7:0] data, input int high_pct,
                           input int busy_pct);
    send_item('{OP_REQUEST, kind, data, 1'($urandom_range(1))});
    while (seq_phase != iowm_pkg::PH_IDLE) begin
      if ($urandom_range(99) < busy_pct)
        send_item('{OP_REQUEST, 1'($urandom_range(1)), 8'($urandom),
                    1'($urandom_range(1))});
      else if (seq_phase == iowm_pkg::PH_POLL)
        send_tick($urandom_range(99) < high_pct);
      else
        send_tick(1'($urandom_range(1)));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Ticks while idle must change nothing.
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
    send_item('{OP_TICK, KIND_DATA, 8'hFF, 1'b1});
  endtask

  // Command write at reset settings, every acknowledge on its first poll.
  task automatic test_command_write();
    run_write(KIND_COMMAND, 8'hFF, 0, 0);
  endtask

  // Data write with requests arriving while busy and some slow acknowledges.
  task automatic test_busy_requests();
    run_write(KIND_DATA, 8'h00, 40, 25);
  endtask

  // Zero poll limit: the first high poll is a miss; every byte misses.
  task automatic test_zero_poll_limit();
    write_reg(iowm_pkg::CFG_DEVICE_ADDRESS, 10'h0FF);
    write_reg(iowm_pkg::CFG_COMMAND_CONTROL, 10'h000);
    write_reg(iowm_pkg::CFG_DATA_CONTROL, 10'h3FF);
    write_reg(iowm_pkg::CFG_ACK_POLL_LIMIT, 10'd0);
    run_write(KIND_DATA, 8'hA5, 100, 0);
    run_write(KIND_COMMAND, 8'h5A, 100, 0);
  endtask

  // Largest poll limit: the address acknowledge misses after the full count
  // of high polls, the later bytes are acknowledged at once.
  task automatic test_max_poll_limit();
    write_reg(iowm_pkg::CFG_DEVICE_ADDRESS, 10'h300);
    write_reg(iowm_pkg::CFG_COMMAND_CONTROL, 10'h0FF);
    write_reg(iowm_pkg::CFG_DATA_CONTROL, 10'h000);
    write_reg(iowm_pkg::CFG_ACK_POLL_LIMIT, 10'd1023);
    send_item('{OP_REQUEST, KIND_COMMAND, 8'h3C, 1'b0});
    while (seq_phase != iowm_pkg::PH_IDLE) begin
      send_tick(byte_cnt == 2'd0);
    end
  endtask

  function automatic logic [iowm_pkg::CfgDataWidth-1:0] pick_byte_setting();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 10'h0FF;
      default: return iowm_pkg::CfgDataWidth'($urandom);
    endcase
  endfunction

  task automatic randomize_registers();
    logic [iowm_pkg::CfgDataWidth-1:0] limit;
    case ($urandom_range(5))
      0:       limit = '0;
      1:       limit = 10'd1;
      2:       limit = 10'($urandom_range(12, 2));
      default: limit = 10'($urandom_range(4));
    endcase
    write_reg(iowm_pkg::CFG_DEVICE_ADDRESS, pick_byte_setting());
    write_reg(iowm_pkg::CFG_COMMAND_CONTROL, pick_byte_setting());
    write_reg(iowm_pkg::CFG_DATA_CONTROL, pick_byte_setting());
    write_reg(iowm_pkg::CFG_ACK_POLL_LIMIT, limit);
  endtask

  // Random writes under one idling mix, with noise between them.
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int unsigned target;
    int          high_pct;
    set_idling(send_pct, recv_pct);
    randomize_registers();
    target = counted_items + ITEMS_PER_MIX;
    while (counted_items < target) begin
      if ($urandom_range(99) < 8) randomize_registers();
      // Pause the sender until the output side has caught up.
      if ($urandom_range(99) < 5) wait_results_drained();
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(3))
          0:       high_pct = 0;
          1:       high_pct = 30;
          2:       high_pct = 70;
          default: high_pct = 100;
        endcase
        run_write(1'($urandom_range(1)), 8'($urandom), high_pct,
                  $urandom_range(1) ? 0 : 10);
      end else begin
        repeat ($urandom_range(4, 1)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  // Receiver: stall at random at the configured rate.
  always @(negedge clk) begin
    line_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    iowm_pkg::result_t exp_r;
    if (!rst && line_ch.valid && line_ch.ready) begin
      if (line_expect_q.size() == 0) begin
        $display("%0t ns: result with no item outstanding", $time);
        error_count++;
      end else begin
        exp_r = line_expect_q.pop_front();
        if (line_ch.scl_level != exp_r.scl_level)
          report_mismatch("scl_level", exp_r.scl_level, line_ch.scl_level);
        if (line_ch.sda_level != exp_r.sda_level)
          report_mismatch("sda_level", exp_r.sda_level, line_ch.sda_level);
        if (line_ch.sda_drive_on != exp_r.sda_drive_on)
          report_mismatch("sda_drive_on", exp_r.sda_drive_on, line_ch.sda_drive_on);
        if (line_ch.busy_res != exp_r.busy_res)
          report_mismatch("busy_res", exp_r.busy_res, line_ch.busy_res);
        if (line_ch.done_res != exp_r.done_res)
          report_mismatch("done_res", exp_r.done_res, line_ch.done_res);
        if (line_ch.missed_acks != exp_r.missed_acks)
          report_mismatch("missed_acks", exp_r.missed_acks, line_ch.missed_acks);
      end
    end
  end

  // Watchdog: drop the run after too long without any transfer.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (line_ch.valid && line_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("i2c_oled_write_master_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    error_count       = 0;
    quiet_cycles      = 0;
    counted_items     = 0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = iowm_pkg::CFG_DEVICE_ADDRESS;
    cfg_data          = '0;
    item_ch.valid     = 1'b0;
    item_ch.op        = OP_TICK;
    item_ch.is_data   = KIND_COMMAND;
    item_ch.payload   = '0;
    item_ch.sda_sense = 1'b1;
    line_ch.ready     = 1'b0;
    set_idling(0, 0);
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed checks first, without idling.
    test_idle_ticks();
    test_command_write();
    test_busy_requests();
    test_zero_poll_limit();
    test_max_poll_limit();

    // Random traffic under each idling mix.
    test_random_traffic(0, 0);
    test_random_traffic(60, 0);
    test_random_traffic(0, 60);
    test_random_traffic(10, 10);

    // Let every result drain, then give the buffer a few more cycles.
    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (line_expect_q.size() != 0) begin
      $display("%0d results never arrived", line_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("i2c_oled_write_master_core_tb: clean");
    end else begin
      $display("i2c_oled_write_master_core_tb: errors");
    end
    $finish;
  end

endmodule
